[rtl/modular_exponentiation_defines.svh]
// Assertion macros shared by the modular exponentiation checker.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Clocked property that is ignored while reset is asserted.
`define MEXP_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("modular exponentiation check failed");

// Clocked property that is also checked through reset.
`define MEXP_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("modular exponentiation reset check failed");

`endif

[rtl/modexp_pkg.sv]
// Types, constants and state codes of the modular exponentiation block.
package modexp_pkg;

    localparam int BASE_W       = 30;
    localparam int EXP_W        = 32;
    localparam int EXP_BITS_DEF = 32;
    localparam int SUM_W        = BASE_W + 2;
    localparam int CNT_W        = $clog2(BASE_W + 1);

    typedef logic [BASE_W-1:0] t_res;
    typedef logic [EXP_W-1:0]  t_exp;

    localparam t_res              MODULUS  = 30'd1000000007;
    localparam logic [SUM_W-1:0]  MOD1_EXT = 32'd1000000007;
    localparam logic [SUM_W-1:0]  MOD2_EXT = 32'd2000000014;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_FIN
    } t_state;

endpackage

[rtl/modexp_in_if.sv]
// Input channel of the modular exponentiation block: base and exponent.
interface modexp_in_if;
    import modexp_pkg::*;

    logic valid;
    logic ready;
    t_res base;
    t_exp exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink (input valid, input base, input exponent, output ready);
endinterface

[rtl/modexp_out_if.sv]
// Result channel of the modular exponentiation block: the power.
interface modexp_out_if;
    import modexp_pkg::*;

    logic valid;
    logic ready;
    t_res power;

    modport source (output valid, output power, input ready);
    modport sink (input valid, input power, output ready);
endinterface

[rtl/modexp_mul.sv]
// Bit-serial modular multiplier: one bit of the second operand per cycle.
module modexp_mul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  modexp_pkg::t_res i_a,
    input  modexp_pkg::t_res i_b,
    output modexp_pkg::t_res o_prod,
    output logic             o_done
);
    import modexp_pkg::*;

    t_res             r_acc, n_acc;
    t_res             r_mul, n_mul;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] w_red;

    // The partial result stays below the modulus, so the doubled value plus
    // the multiplicand is below three times the modulus.
    always_comb begin
        w_sum = {1'b0, r_acc, 1'b0} + (r_mul[BASE_W-1] ? {2'b00, i_a} : '0);
        if (w_sum >= MOD2_EXT) begin
            w_red = w_sum - MOD2_EXT;
        end else if (w_sum >= MOD1_EXT) begin
            w_red = w_sum - MOD1_EXT;
        end else begin
            w_red = w_sum;
        end
    end

    always_comb begin
        n_acc  = r_acc;
        n_mul  = r_mul;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc  = '0;
            n_mul  = i_b;
            n_cnt  = CNT_W'(BASE_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = w_red[BASE_W-1:0];
            n_mul = {r_mul[BASE_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_mul <= n_mul;
    end

    assign o_prod = r_acc;
    assign o_done = r_done;
endmodule

[rtl/modular_exponentiation.sv]
// Modular exponentiation top level: base to the power exponent modulo 1000000007.
// Right-to-left square-and-multiply over the exponent bits, with two bit-serial
// modular multipliers that form the product and the next square side by side.
// Each scanned exponent bit starts the multipliers, runs the bit-serial multiply
// over the 30 operand bits, and then takes the products. Scanning stops after
// the highest set bit; a zero base or zero exponent skips the multiplies. One
// item is in work at a time; a new beat is accepted as soon as the previous
// result sits in the output register.
// Exponent bits at or above EXP_BITS are ignored, and a zero base yields zero.
module modular_exponentiation #(
    parameter int EXP_BITS = modexp_pkg::EXP_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    modexp_in_if.sink    i_in,
    modexp_out_if.source o_res
);
    import modexp_pkg::*;

    localparam t_exp EXP_MASK = (EXP_BITS >= EXP_W) ? '1
                                : EXP_W'((64'd1 << EXP_BITS) - 64'd1);

    t_state r_state, n_state;
    t_res   r_acc, n_acc;
    t_res   r_sq, n_sq;
    t_exp   r_exp, n_exp;
    t_res   r_power, n_power;
    logic   r_out_valid, n_out_valid;

    t_res   w_base;
    logic   w_start;
    t_res   w_prod_acc, w_prod_sq;
    logic   w_done_acc, w_done_sq;

    assign w_base  = (i_in.base >= MODULUS) ? i_in.base - MODULUS : i_in.base;
    assign w_start = (r_state == S_CHECK) && (r_exp != '0);

    modexp_mul u_mul_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (r_sq),
        .i_b     (r_acc),
        .o_prod  (w_prod_acc),
        .o_done  (w_done_acc)
    );

    modexp_mul u_mul_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (r_sq),
        .i_b     (r_sq),
        .o_prod  (w_prod_sq),
        .o_done  (w_done_sq)
    );

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_exp       = r_exp;
        n_power     = r_power;
        n_out_valid = r_out_valid;
        i_in.ready  = (r_state == S_IDLE);

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_sq    = w_base;
                    n_acc   = (w_base == '0) ? '0 : t_res'(1);
                    n_exp   = (w_base == '0) ? '0 : (i_in.exponent & EXP_MASK);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = (r_exp == '0) ? S_FIN : S_MUL;
            end
            S_MUL: begin
                // Both multipliers start together and finish together.
                if (w_done_sq && w_done_acc) begin
                    if (r_exp[0]) begin
                        n_acc = w_prod_acc;
                    end
                    n_sq    = w_prod_sq;
                    n_exp   = {1'b0, r_exp[EXP_W-1:1]};
                    n_state = S_CHECK;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_res.ready) begin
                    n_power     = r_acc;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_acc   <= n_acc;
        r_sq    <= n_sq;
        r_exp   <= n_exp;
        r_power <= n_power;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.power = r_power;
endmodule

[rtl/modexp_chk.sv]
// Port-level checker for the modular exponentiation block, with its bind.
`include "modular_exponentiation_defines.svh"

module modexp_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input modexp_pkg::t_res i_res_power
);
    import modexp_pkg::*;

    // No result beat may show up in the cycle after reset.
    `MEXP_ASSERT_RST(a_no_result_after_reset, !i_rst_n |=> !i_res_valid)

    // A result beat that is held back keeps its value.
    `MEXP_ASSERT(a_result_holds, i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_power))

    // Every result is fully reduced.
    `MEXP_ASSERT(a_result_reduced, i_res_valid |-> i_res_power < MODULUS)

    // One item at a time: after an accepted beat the input closes.
    `MEXP_ASSERT(a_one_in_flight, i_in_valid && i_in_ready |=> !i_in_ready)
endmodule

bind modular_exponentiation modexp_chk u_modexp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_power (o_res.power)
);
